### sv/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the box mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

    localparam int unsigned COL_BITS   = 10;
    localparam int unsigned ROW_BITS   = 12;
    localparam int unsigned MEAN_BITS  = 24;
    localparam int unsigned IN_BITS    = 16;
    localparam int unsigned FW_BITS    = 11;
    localparam int unsigned FH_BITS    = 13;
    localparam int unsigned RAD_BITS   = 3;
    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int unsigned OUT_BYTES  = 6;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RD,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } bmf_state_t;

endpackage

`default_nettype wire

### sv/bmf_ram.sv
// ----------------------------------------------------------------------------
// bmf_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sv/box_mean_filter_unit.sv
// ----------------------------------------------------------------------------
// box_mean_filter_unit
// Clipped-border box mean over a raster frame, Q8 fixed-point result.
// ----------------------------------------------------------------------------
// usage:
//   s_ side takes one pixel word per transfer in raster order (tdata[15:0]).
//   m_ side gives one word per filtered pixel: column, row and mean*256
//   (truncated); tlast marks the final word caused by one input pixel.
//   a pixel is written into a line memory of 2*MAX_RADIUS+1 rows. when it
//   closes one or more windows, each window sum is read back from the line
//   memory one pixel at a time (a read state, then an accumulate state) and
//   divided by a restoring divider that retires one quotient bit per cycle.
//   when no window closes, a new pixel can be taken every clock; otherwise each
//   result takes a setup step, a read and an accumulate step per window pixel,
//   the division and the output step; a window spans up to 2*R+1 rows and cols.
//   s_tready is high only while no result is being formed or held.
//   a stalled receiver holds the result word; no input is taken meanwhile.
//   reset sets the registers to 640 x 480, radius 1, and the position to 0.
//   a write to any of the three mapped registers restarts the frame at pixel (0,0).
// ----------------------------------------------------------------------------
`default_nettype none

module box_mean_filter_unit #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_RADIUS = 7,
    parameter int unsigned PIXEL_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // pixel[15:0]
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_col[9:0] out_row[21:10] mean_q8[45:22]
    output logic             m_tlast    // last
);

    import bmf_pkg::*;

    localparam int unsigned SLOTS = 2 * MAX_RADIUS + 1;
    localparam int unsigned SLW   = $clog2(SLOTS);
    localparam int unsigned AW    = $clog2(SLOTS * MAX_WIDTH);
    localparam int unsigned PW    = (PIXEL_BITS < IN_BITS) ? PIXEL_BITS : IN_BITS;
    localparam int unsigned SW    = PW + 8;
    localparam int unsigned DB    = SW + 8;
    localparam int unsigned KW    = $clog2(DB + 1);
    localparam int unsigned VW    = 14;

    // configuration registers
    logic [FW_BITS-1:0]  fw_reg;
    logic [FH_BITS-1:0]  fh_reg;
    logic [RAD_BITS-1:0] rad_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:   prdata = 32'(fw_reg);
            REG_FRAME_HEIGHT:  prdata = 32'(fh_reg);
            REG_WINDOW_RADIUS: prdata = 32'(rad_reg);
            default:           prdata = 32'd0;
        endcase
    end

    // effective values
    logic [VW-1:0] w_eff, h_eff, r_eff;
    always_comb begin
        if (fw_reg == '0)                       w_eff = VW'(1);
        else if (32'(fw_reg) > MAX_WIDTH)       w_eff = VW'(MAX_WIDTH);
        else                                    w_eff = VW'(fw_reg);
        if (fh_reg == '0)                       h_eff = VW'(1);
        else if (32'(fh_reg) > MAX_HEIGHT)      h_eff = VW'(MAX_HEIGHT);
        else                                    h_eff = VW'(fh_reg);
        if (32'(rad_reg) > MAX_RADIUS)          r_eff = VW'(MAX_RADIUS);
        else                                    r_eff = VW'(rad_reg);
    end

    bmf_state_t state_reg, state_next;

    logic [VW-1:0]  cx_reg, cy_reg;
    logic [SLW-1:0] cslot_reg;
    logic [VW-1:0]  pcx_reg, pcy_reg, r_reg;
    logic [SLW-1:0] pslot_reg;
    logic [VW-1:0]  xlo_reg, xhi_reg, yhi_reg;
    logic [VW-1:0]  x_reg, y_reg, c0_reg, xx_reg, yy_reg;
    logic [SLW-1:0] ys_reg;
    logic [SW-1:0]  sum_reg;
    logic [7:0]     cnt_reg;
    logic [DB-1:0]  num_reg;
    logic [8:0]     rem_reg;
    logic [KW-1:0]  k_reg;
    logic [47:0]    out_reg;
    logic           last_reg;

    // span of windows closed by the incoming pixel
    logic [VW-1:0] wm1, hm1, sxlo, sxhi, sylo, syhi;
    logic          xok, yok;
    always_comb begin
        wm1 = w_eff - VW'(1);
        hm1 = h_eff - VW'(1);
        xok = (cx_reg == wm1) || (cx_reg >= r_eff);
        yok = (cy_reg == hm1) || (cy_reg >= r_eff);
        if (cx_reg == wm1) begin
            sxlo = (wm1 >= r_eff) ? wm1 - r_eff : '0;
            sxhi = wm1;
        end else begin
            sxlo = cx_reg - r_eff;
            sxhi = cx_reg - r_eff;
        end
        if (cy_reg == hm1) begin
            sylo = (hm1 >= r_eff) ? hm1 - r_eff : '0;
            syhi = hm1;
        end else begin
            sylo = cy_reg - r_eff;
            syhi = cy_reg - r_eff;
        end
    end

    logic s_acc, m_acc, hit;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign hit   = xok && yok;

    // window setup for the current result
    logic [VW-1:0]  r0, c0, dr;
    logic [SLW-1:0] ys0;
    logic [3:0]     nrows, ncols;
    always_comb begin
        r0    = (y_reg >= r_reg) ? y_reg - r_reg : '0;
        c0    = (x_reg >= r_reg) ? x_reg - r_reg : '0;
        dr    = pcy_reg - r0;
        ys0   = (VW'(pslot_reg) >= dr) ? SLW'(VW'(pslot_reg) - dr)
                                       : SLW'(VW'(pslot_reg) + VW'(SLOTS) - dr);
        nrows = 4'(dr + VW'(1));
        ncols = 4'(pcx_reg - c0 + VW'(1));
    end

    // division step
    logic [8:0] trial;
    logic       ge;
    assign trial = {rem_reg[7:0], num_reg[DB-1]};
    assign ge    = trial >= 9'(cnt_reg);

    // line memory
    logic [AW-1:0] wr_addr, rd_addr;
    logic [PW-1:0] rd_data;
    assign wr_addr = AW'(32'(cslot_reg) * MAX_WIDTH + 32'(cx_reg));
    assign rd_addr = AW'(32'(ys_reg) * MAX_WIDTH + 32'(xx_reg));

    bmf_ram #(
        .WIDTH (PW),
        .DEPTH (SLOTS * MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s_acc),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[PW-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [SW-1:0] sum_add;
    logic          row_end, win_end;
    assign sum_add = sum_reg + SW'(rd_data);
    assign row_end = (xx_reg == pcx_reg);
    assign win_end = row_end && (yy_reg == pcy_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_acc && hit) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_RD;
            ST_RD:    state_next = ST_ACC;
            ST_ACC:   state_next = win_end ? ST_DIV : ST_RD;
            ST_DIV:   if (k_reg == KW'(1)) state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) state_next = last_reg ? ST_IDLE : ST_SETUP;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = out_reg;
        m_tlast  = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fw_reg    <= FW_BITS'(640);
            fh_reg    <= FH_BITS'(480);
            rad_reg   <= RAD_BITS'(1);
            cx_reg    <= '0;
            cy_reg    <= '0;
            cslot_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_FRAME_WIDTH:   fw_reg  <= pwdata[FW_BITS-1:0];
                    REG_FRAME_HEIGHT:  fh_reg  <= pwdata[FH_BITS-1:0];
                    REG_WINDOW_RADIUS: rad_reg <= pwdata[RAD_BITS-1:0];
                    default: ;
                endcase
                if (paddr[3:2] == REG_FRAME_WIDTH || paddr[3:2] == REG_FRAME_HEIGHT ||
                    paddr[3:2] == REG_WINDOW_RADIUS) begin
                    cx_reg    <= '0;
                    cy_reg    <= '0;
                    cslot_reg <= '0;
                end
            end else if (s_acc) begin
                if (cx_reg + VW'(1) >= w_eff) begin
                    cx_reg <= '0;
                    if (cy_reg + VW'(1) >= h_eff) begin
                        cy_reg    <= '0;
                        cslot_reg <= '0;
                    end else begin
                        cy_reg    <= cy_reg + VW'(1);
                        cslot_reg <= (32'(cslot_reg) == SLOTS - 1) ? '0
                                                                   : cslot_reg + SLW'(1);
                    end
                end else begin
                    cx_reg <= cx_reg + VW'(1);
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                pcx_reg   <= cx_reg;
                pcy_reg   <= cy_reg;
                pslot_reg <= cslot_reg;
                r_reg     <= r_eff;
                xlo_reg   <= sxlo;
                xhi_reg   <= sxhi;
                yhi_reg   <= syhi;
                x_reg     <= sxlo;
                y_reg     <= sylo;
            end
            ST_SETUP: begin
                c0_reg  <= c0;
                xx_reg  <= c0;
                yy_reg  <= r0;
                ys_reg  <= ys0;
                sum_reg <= '0;
                cnt_reg <= 8'(nrows) * 8'(ncols);
            end
            ST_ACC: begin
                sum_reg <= sum_add;
                if (row_end) begin
                    xx_reg <= c0_reg;
                    yy_reg <= yy_reg + VW'(1);
                    ys_reg <= (32'(ys_reg) == SLOTS - 1) ? '0 : ys_reg + SLW'(1);
                end else begin
                    xx_reg <= xx_reg + VW'(1);
                end
                num_reg <= {sum_add, 8'd0};
                rem_reg <= '0;
                k_reg   <= KW'(DB);
            end
            ST_DIV: begin
                rem_reg <= ge ? trial - 9'(cnt_reg) : trial;
                num_reg <= {num_reg[DB-2:0], ge};
                k_reg   <= k_reg - KW'(1);
                if (k_reg == KW'(1)) begin
                    out_reg  <= {2'b00,
                                 MEAN_BITS'({num_reg[DB-2:0], ge}),
                                 ROW_BITS'(32'(y_reg)),
                                 COL_BITS'(32'(x_reg))};
                    last_reg <= (x_reg == xhi_reg) && (y_reg == yhi_reg);
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    if (x_reg == xhi_reg) begin
                        x_reg <= xlo_reg;
                        y_reg <= y_reg + VW'(1);
                    end else begin
                        x_reg <= x_reg + VW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### sv/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks of the box mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast
);

    // a held word keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // no pixel taken while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // nothing pending right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid after reset");

endmodule

bind box_mean_filter_unit bmf_checker u_bmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### bench/bmf_result_checker.sv
// ----------------------------------------------------------------------------
// bmf_result_checker
// Watches the pixel, result and register channels of the box mean filter.
// Keeps its own line memory and frame position, works out the clipped-window
// means each accepted pixel closes, and compares every result word against
// the oldest of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmf_result_checker
    import bmf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending,
    output int               pixels_seen,
    output int               words_seen
);

    localparam int LINE_MAX  = 1024;
    localparam int RAD_MAX   = 7;
    localparam int LINE_ROWS = 2 * RAD_MAX + 1;

    typedef struct packed {
        logic [COL_BITS-1:0]  col;
        logic [ROW_BITS-1:0]  row;
        logic [MEAN_BITS-1:0] mean;
        logic                 last;
    } mean_word_t;

    logic [IN_BITS-1:0]  line_mem [LINE_ROWS][LINE_MAX];
    logic [FW_BITS-1:0]  width_reg;
    logic [FH_BITS-1:0]  height_reg;
    logic [RAD_BITS-1:0] radius_reg;
    int                  cur_col;
    int                  cur_row;
    mean_word_t          expected_means[$];

    // rows or columns whose clipped window closes at position p
    function automatic bit closing_span(input int p, input int size, input int rad,
                                        output int lo, output int hi);
        if (p == size - 1) begin
            lo = (size - 1 - rad > 0) ? size - 1 - rad : 0;
            hi = size - 1;
            return 1'b1;
        end
        lo = p - rad;
        hi = p - rad;
        return p >= rad;
    endfunction

    task automatic predict_window_means(input logic [IN_BITS-1:0] pix);
        int         w;
        int         h;
        int         rad;
        int         xlo;
        int         xhi;
        int         ylo;
        int         yhi;
        int         r0;
        int         c0;
        longint     sum;
        longint     cnt;
        mean_word_t word;
        bit         got_x;
        bit         got_y;
        int         first_new;
        w   = (width_reg == 0) ? 1 : (width_reg > LINE_MAX ? LINE_MAX : int'(width_reg));
        h   = (height_reg == 0) ? 1 :
              (height_reg > MAX_HEIGHT ? MAX_HEIGHT : int'(height_reg));
        rad = (radius_reg > RAD_MAX) ? RAD_MAX : int'(radius_reg);
        line_mem[cur_row % LINE_ROWS][cur_col] = pix;
        first_new = expected_means.size();
        got_x = closing_span(cur_col, w, rad, xlo, xhi);
        got_y = closing_span(cur_row, h, rad, ylo, yhi);
        if (got_x && got_y) begin
            for (int y = ylo; y <= yhi; y++) begin
                r0 = (y - rad > 0) ? y - rad : 0;
                for (int x = xlo; x <= xhi; x++) begin
                    c0  = (x - rad > 0) ? x - rad : 0;
                    sum = 0;
                    for (int yy = r0; yy <= cur_row; yy++)
                        for (int xx = c0; xx <= cur_col; xx++)
                            sum += line_mem[yy % LINE_ROWS][xx];
                    cnt = longint'(cur_row - r0 + 1) * longint'(cur_col - c0 + 1);
                    word.col  = x[COL_BITS-1:0];
                    word.row  = y[ROW_BITS-1:0];
                    word.mean = MEAN_BITS'((sum << 8) / cnt);
                    word.last = 1'b0;
                    expected_means.push_back(word);
                end
            end
            if (expected_means.size() > first_new)
                expected_means[expected_means.size() - 1].last = 1'b1;
        end
        cur_col++;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h) cur_row = 0;
        end
    endtask

    always @(posedge aclk) begin
        mean_word_t want;
        if (!aresetn) begin
            width_reg  = 11'd640;
            height_reg = 13'd480;
            radius_reg = 3'd1;
            cur_col    = 0;
            cur_row    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_FRAME_WIDTH: begin
                        width_reg = pwdata[FW_BITS-1:0];
                        cur_col = 0;
                        cur_row = 0;
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = pwdata[FH_BITS-1:0];
                        cur_col = 0;
                        cur_row = 0;
                    end
                    REG_WINDOW_RADIUS: begin
                        radius_reg = pwdata[RAD_BITS-1:0];
                        cur_col = 0;
                        cur_row = 0;
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_window_means(s_tdata[IN_BITS-1:0]);
                pixels_seen++;
            end
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (expected_means.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_means.pop_front();
                    if (m_tdata[9:0] !== want.col) begin
                        $error("out_col expected %0d got %0d", want.col, m_tdata[9:0]);
                        fail_count++;
                    end
                    if (m_tdata[21:10] !== want.row) begin
                        $error("out_row expected %0d got %0d", want.row, m_tdata[21:10]);
                        fail_count++;
                    end
                    if (m_tdata[45:22] !== want.mean) begin
                        $error("mean_q8 expected %0d got %0d", want.mean, m_tdata[45:22]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last expected %0d got %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_means.size();
    end

    initial begin
        fail_count  = 0;
        pending     = 0;
        pixels_seen = 0;
        words_seen  = 0;
        for (int r = 0; r < LINE_ROWS; r++)
            for (int c = 0; c < LINE_MAX; c++)
                line_mem[r][c] = '0;
    end

endmodule

### bench/box_mean_filter_unit_test.sv
// ----------------------------------------------------------------------------
// box_mean_filter_unit_test
// Drives pixel frames and register settings into the box mean filter, from
// single-pixel frames to full-width rows and the largest radius, with random
// sender gaps and receiver stalls; the checker judges every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_mean_filter_unit_test;
    import bmf_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int         IDLE_LIMIT   = 40000;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // pixel[15:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // out_col[9:0] out_row[21:10] mean_q8[45:22]
    logic        m_tlast;   // last

    int fail_count;
    int pending;
    int pixels_seen;
    int words_seen;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int settings_run;

    box_mean_filter_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    bmf_result_checker result_chk (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending),
        .pixels_seen(pixels_seen), .words_seen(words_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles with no word moving on either channel and no register access
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // field bits above the register width are random filler
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value,
                             input int bits);
        logic [31:0] filler;
        filler = $urandom;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (filler << bits) | value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_frame(input int w, input int h, input int rad);
        wait_drained();
        reg_write(REG_FRAME_WIDTH, w, FW_BITS);
        reg_write(REG_FRAME_HEIGHT, h, FH_BITS);
        reg_write(REG_WINDOW_RADIUS, rad, RAD_BITS);
        settings_run++;
    endtask

    task automatic send_pixel(input logic [15:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int w_raw [12] = '{5, 1, 9, 2047, 8, 3, 7, 0, 12, 4, 1024, 6};
        int h_raw [12] = '{4, 7, 9, 1, 3, 8191, 6, 0, 3, 4, 2, 5};
        int r_raw [12] = '{1, 2, 7, 3, 0, 5, 4, 6, 2, 7, 1, 3};
        int frame_px;
        int count;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settings_run   = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: 3x3 frame at radius 1 with extreme samples
        set_frame(3, 3, 1);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 16'hFFFF : 16'h0000);
        s_tvalid <= 1'b0;
        // radius zero: each pixel is its own mean; the unmapped write changes nothing
        set_frame(4, 2, 0);
        reg_write(REG_UNMAPPED, 32'h5, 0);
        for (int i = 0; i < 8; i++)
            send_pixel(16'h1 << (2 * i + 1));
        s_tvalid <= 1'b0;
        // zero size clamps to a one-pixel frame, radius 6 clipped everywhere
        set_frame(0, 0, 6);
        send_pixel(16'hFFFF);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < 12; ph++) begin
            set_frame(w_raw[ph], h_raw[ph], r_raw[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            frame_px = (w_raw[ph] == 0 ? 1 : (w_raw[ph] > 1024 ? 1024 : w_raw[ph])) *
                       (h_raw[ph] == 0 ? 1 : (h_raw[ph] > 4096 ? 4096 : h_raw[ph]));
            // a frame and a bit more to cross the wrap, capped for the big ones
            count = frame_px + frame_px / 3;
            if (count > 36) count = 36;
            if (count < 20) count = 20;
            for (int i = 0; i < count; i++)
                send_pixel(random_pixel());
            s_tvalid <= 1'b0;
        end

        recv_stall_pct = 0;
        wait_drained();
        repeat (40) @(posedge aclk);
        $display("pixels sent %0d, mean words checked %0d", pixels_seen, words_seen);
        $display("frame settings %0d, radius 0..7, widths 1..1024, heights 1..4096",
                 settings_run);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
